// ----- rtl/light_falloff_pixel_generator_top_macros.svh -----
// Assertion macros shared by the light falloff pixel generator RTL.
// Included by the top level, which carries the concurrent checks; no other dependencies.
`ifndef LIGHT_FALLOFF_PIXEL_GENERATOR_TOP_MACROS_SVH
`define LIGHT_FALLOFF_PIXEL_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define LFPG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfpg assertion violated");
// Next-cycle implication.
`define LFPG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfpg assertion violated");
`else
`define LFPG_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LFPG_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/lfpg_pkg.sv -----
// Shared types, constants and tables of the light falloff pixel generator.
// No dependencies.
`default_nettype none
package lfpg_pkg;

  localparam int F            = 16;          // intensity fraction bits
  localparam int MAX_RADIUS   = 256;
  localparam int CORDIC_STEPS = 18;

  localparam logic [16:0] ONE         = 17'd65536;
  localparam logic [23:0] DEG90       = 24'd5898240;
  localparam logic [23:0] DEG180      = 24'd11796480;
  localparam logic [32:0] CORDIC_GAIN = 33'd652032874;

  localparam logic [2:0] REG_LIGHT_RADIUS    = 3'd0;
  localparam logic [2:0] REG_SPOT_MODE       = 3'd1;
  localparam logic [2:0] REG_DIFFUSE_FALLOFF = 3'd2;
  localparam logic [2:0] REG_CONE_ANGLE      = 3'd3;
  localparam logic [2:0] REG_LIGHT_COLOR     = 3'd4;

  typedef struct packed {
    logic in_radius;
    logic d2nz;
    logic dxz;
    logic dyz;
    logic dyneg;
  } geo_flags_t;

  // Arctangent of 2^-i in degrees, 16 fraction bits.
  function automatic logic [21:0] atan_q16(input int i);
    logic [21:0] v;
    case (i)
      0:  v = 22'd2949120;
      1:  v = 22'd1740967;
      2:  v = 22'd919879;
      3:  v = 22'd466945;
      4:  v = 22'd234379;
      5:  v = 22'd117304;
      6:  v = 22'd58666;
      7:  v = 22'd29335;
      8:  v = 22'd14668;
      9:  v = 22'd7334;
      10: v = 22'd3667;
      11: v = 22'd1833;
      12: v = 22'd917;
      13: v = 22'd458;
      14: v = 22'd229;
      15: v = 22'd115;
      16: v = 22'd57;
      17: v = 22'd29;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/lfpg_cos_pipe.sv -----
// Pipelined falloff unit: linear 1 - q or quarter-cosine of q by CORDIC rotation.
// Depends on lfpg_pkg. Twenty register stages, all advancing on en.
`default_nettype none
module lfpg_cos_pipe (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic        diffuse,
  input  wire logic [16:0] q,
  output logic      [16:0] inten
);
  import lfpg_pkg::*;

  logic signed [32:0] cx [0:CORDIC_STEPS];
  logic signed [32:0] cy [0:CORDIC_STEPS];
  logic signed [24:0] cz [0:CORDIC_STEPS];
  logic               zf [0:CORDIC_STEPS];
  logic        [16:0] lin [0:CORDIC_STEPS];

  logic [16:0] qc;
  logic [23:0] z0;
  assign qc = (q > ONE) ? ONE : q;
  assign z0 = {7'b0, qc} * 24'd90;

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]  <= CORDIC_GAIN;
      cy[0]  <= '0;
      cz[0]  <= $signed({1'b0, z0});
      zf[0]  <= (qc == 17'd0);
      lin[0] <= ONE - qc;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [32:0] nx, ny;
    logic signed [24:0] nz, at;
    assign at = $signed({3'b0, atan_q16(i)});
    always_comb begin
      if (cz[i] >= 0) begin
        nx = cx[i] - (cy[i] >>> i);
        ny = cy[i] + (cx[i] >>> i);
        nz = cz[i] - at;
      end else begin
        nx = cx[i] + (cy[i] >>> i);
        ny = cy[i] - (cx[i] >>> i);
        nz = cz[i] + at;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cx[i+1]  <= nx;
        cy[i+1]  <= ny;
        cz[i+1]  <= nz;
        zf[i+1]  <= zf[i];
        lin[i+1] <= lin[i];
      end
    end
  end

  logic [32:0] xr, xv;
  logic [16:0] cosv;
  always_comb begin
    xr = cx[CORDIC_STEPS] + 33'(1 << (29 - F));
    xv = xr >> (30 - F);
    if (zf[CORDIC_STEPS]) begin
      cosv = ONE;
    end else if (cx[CORDIC_STEPS] <= 0) begin
      cosv = '0;
    end else if (xv > {16'b0, ONE}) begin
      cosv = ONE;
    end else begin
      cosv = xv[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inten <= diffuse ? cosv : lin[CORDIC_STEPS];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/light_falloff_pixel_generator_top.sv -----
// Top level of the light falloff pixel generator: config registers, distance
// and angle pipelines, color scaling. Depends on lfpg_pkg, lfpg_cos_pipe and the macros header.
//
// Usage: pixel coordinates enter on the s_ stream, one word per clock, and each
// gives exactly one RGBA word on the m_ stream, in order. s_tdata carries
// pixel_col in bits 8:0 and pixel_row in bits 17:9. m_tdata carries pixel_rgba
// and m_tuser the lit flag.
// The path from an accepted word to its result is set by 16 root-search steps,
// an 18-step vectoring CORDIC, a 17-step restoring divider and an 18-step
// rotation CORDIC, one step per stage.
// Throughput: one word per cycle while the receiver takes results.
// All stages advance together when the output register is empty or taken; when
// the receiver stalls, the whole pipeline holds and s_tready drops.
// Reset clears the pipeline valid bits and loads the register reset values.
// The user writes configuration through cfg_we/cfg_addr/cfg_wdata only while idle; the block does not enforce it.
`default_nettype none
`include "light_falloff_pixel_generator_top_macros.svh"
module light_falloff_pixel_generator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // pixel_col [8:0], pixel_row [17:9], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // pixel_rgba [31:0]
  output logic             m_tuser    // lit [0]
);
  import lfpg_pkg::*;

  localparam int S_OUT = 59;

  // Configuration registers.
  logic [8:0]  light_radius;
  logic        spot_mode;
  logic        diffuse_falloff;
  logic [16:0] cone_angle;
  logic [31:0] light_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_radius    <= 9'd64;
      spot_mode       <= 1'b0;
      diffuse_falloff <= 1'b0;
      cone_angle      <= 17'd11520;
      light_color     <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LIGHT_RADIUS:    light_radius    <= cfg_wdata[8:0];
        REG_SPOT_MODE:       spot_mode       <= cfg_wdata[0];
        REG_DIFFUSE_FALLOFF: diffuse_falloff <= cfg_wdata[0];
        REG_CONE_ANGLE:      cone_angle      <= cfg_wdata[16:0];
        REG_LIGHT_COLOR:     light_color     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [8:0]  rad;
  logic [17:0] r2w;
  logic [16:0] r2;
  logic [23:0] half;
  assign rad  = (light_radius > 9'(MAX_RADIUS)) ? 9'(MAX_RADIUS) : light_radius;
  assign r2w  = {9'b0, rad} * {9'b0, rad};
  assign r2   = r2w[16:0];
  assign half = {cone_angle, 7'b0};

  // Pipeline control.
  logic [S_OUT:1] vld;
  logic           adv;
  assign adv      = !vld[S_OUT] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[S_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[S_OUT-1:1], s_tvalid};
    end
  end

  // Stage 1: offsets and squared distance.
  logic [8:0]        col, row, ax, ay;
  logic signed [9:0] dx, dy;
  logic [19:0]       d2;
  assign col = s_tdata[8:0];
  assign row = s_tdata[17:9];
  assign dx  = $signed({1'b0, col}) - $signed({1'b0, rad});
  assign dy  = $signed({1'b0, row}) - $signed({1'b0, rad});
  assign ax  = dx[9] ? 9'(-dx) : dx[8:0];
  assign ay  = dy[9] ? 9'(-dy) : dy[8:0];
  assign d2  = {11'b0, ax} * {11'b0, ax} + {11'b0, ay} * {11'b0, ay};

  logic [19:0]        d2_p [1:F];
  logic [51:0]        sq_s [1:F];
  logic [32:0]        sq_q [1:F];
  logic [F-1:0]       k_p  [1:37];
  logic signed [32:0] vx   [1:19];
  logic signed [32:0] vy   [1:19];
  logic signed [24:0] vz   [1:19];
  geo_flags_t         flg  [1:19];

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_p[1]          <= d2;
      sq_s[1]          <= '0;
      sq_q[1]          <= '0;
      k_p[1]           <= '0;
      vx[1]            <= {4'b0, ay, 20'b0};
      vy[1]            <= {4'b0, ax, 20'b0};
      vz[1]            <= '0;
      flg[1].in_radius <= (rad != 9'd0) && (d2 < {3'b0, r2});
      flg[1].d2nz      <= (d2 != 20'd0);
      flg[1].dxz       <= (dx == 10'sd0);
      flg[1].dyz       <= (dy == 10'sd0);
      flg[1].dyneg     <= dy[9];
    end
  end

  // Distance ratio: bit-serial root search keeping (k*r)^2 and k*r*r updated.
  for (genvar j = 1; j <= F; j++) begin : g_sqrt
    localparam int B = F - j;
    logic [53:0] tt, dd;
    logic        take;
    assign tt   = {2'b0, sq_s[j]} + ({21'b0, sq_q[j]} << (B + 1))
                + ({37'b0, r2} << (2 * B));
    assign dd   = {2'b0, d2_p[j], 32'b0};
    assign take = (tt <= dd);
    always_ff @(posedge clk) begin
      if (adv) begin
        k_p[j+1] <= take ? (k_p[j] | F'(1 << B)) : k_p[j];
      end
    end
    if (j < F) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          d2_p[j+1] <= d2_p[j];
          sq_s[j+1] <= take ? tt[51:0] : sq_s[j];
          sq_q[j+1] <= take ? (sq_q[j] + ({16'b0, r2} << B)) : sq_q[j];
        end
      end
    end
  end

  for (genvar j = F + 1; j < 37; j++) begin : g_kdly
    always_ff @(posedge clk) begin
      if (adv) begin
        k_p[j+1] <= k_p[j];
      end
    end
  end

  // Pixel angle: vectoring CORDIC on (|dy|, |dx|).
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    logic signed [32:0] nx, ny;
    logic signed [24:0] nz, at;
    assign at = $signed({3'b0, atan_q16(i)});
    always_comb begin
      if (vy[1+i] > 0) begin
        nx = vx[1+i] + (vy[1+i] >>> i);
        ny = vy[1+i] - (vx[1+i] >>> i);
        nz = vz[1+i] + at;
      end else begin
        nx = vx[1+i] - (vy[1+i] >>> i);
        ny = vy[1+i] + (vx[1+i] >>> i);
        nz = vz[1+i] - at;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        vx[2+i]  <= nx;
        vy[2+i]  <= ny;
        vz[2+i]  <= nz;
        flg[2+i] <= flg[1+i];
      end
    end
  end

  // Stage 20: angle fix-up, cone test and lit decision.
  logic [23:0] zc, ang;
  logic        lit20;
  always_comb begin
    if (vz[19] < 0) begin
      zc = '0;
    end else if (vz[19] > $signed({1'b0, DEG90})) begin
      zc = DEG90;
    end else begin
      zc = vz[19][23:0];
    end
    if (flg[19].dxz) begin
      ang = flg[19].dyneg ? DEG180 : 24'd0;
    end else if (flg[19].dyz) begin
      ang = DEG90;
    end else begin
      ang = flg[19].dyneg ? (DEG180 - zc) : zc;
    end
    lit20 = flg[19].in_radius && (!spot_mode || (flg[19].d2nz && (ang <= half)));
  end

  logic [40:0] dr    [20:36];
  logic [16:0] dq    [20:37];
  logic        lit_p [20:58];

  always_ff @(posedge clk) begin
    if (adv) begin
      dr[20]    <= {1'b0, ang, 16'b0};
      dq[20]    <= '0;
      lit_p[20] <= lit20;
    end
  end

  // Angular ratio: restoring divider, one quotient bit per stage.
  for (genvar j = 0; j <= F; j++) begin : g_div
    localparam int B = F - j;
    logic [40:0] dv;
    logic        ge;
    assign dv = {17'b0, half} << B;
    assign ge = (dr[20+j] >= dv);
    always_ff @(posedge clk) begin
      if (adv) begin
        dq[21+j] <= ge ? (dq[20+j] | 17'(1 << B)) : dq[20+j];
      end
    end
    if (j < F) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          dr[21+j] <= ge ? (dr[20+j] - dv) : dr[20+j];
        end
      end
    end
  end

  for (genvar j = 20; j < 58; j++) begin : g_litdly
    always_ff @(posedge clk) begin
      if (adv) begin
        lit_p[j+1] <= lit_p[j];
      end
    end
  end

  logic [16:0] arq;
  assign arq = (half == 24'd0) ? 17'd0 : ((dq[37] > ONE) ? ONE : dq[37]);

  logic [16:0] id57, ia57;

  lfpg_cos_pipe u_cos_dist (
    .clk     (clk),
    .en      (adv),
    .diffuse (diffuse_falloff),
    .q       ({1'b0, k_p[37]}),
    .inten   (id57)
  );

  lfpg_cos_pipe u_cos_ang (
    .clk     (clk),
    .en      (adv),
    .diffuse (diffuse_falloff),
    .q       (arq),
    .inten   (ia57)
  );

  // Stage 58: combined intensity. Stage 59: channel scaling.
  logic [33:0] prod;
  logic [16:0] inten58;
  assign prod = {17'b0, id57} * {17'b0, ia57};

  always_ff @(posedge clk) begin
    if (adv) begin
      inten58 <= spot_mode ? prod[32:16] : id57;
    end
  end

  logic [31:0] rgba;
  for (genvar c = 0; c < 4; c++) begin : g_chan
    logic [24:0] cp;
    assign cp = {17'b0, light_color[8*c +: 8]} * {8'b0, inten58};
    assign rgba[8*c +: 8] = lit_p[58] ? cp[23:16] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= rgba;
      m_tuser <= lit_p[58];
    end
  end

  `LFPG_ASSERT_IMP(a_unlit_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == 32'd0)
  `LFPG_ASSERT_NXT(a_stall_freeze, clk, rst, !adv, $stable(vld))
  `LFPG_ASSERT_NXT(a_lit_needs_radius, clk, rst, adv && vld[19] && !flg[19].in_radius, !lit_p[20])

endmodule
`default_nettype wire
